FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the RTL folder.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while the reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that also holds while the reset is asserted.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/mts_pkg.sv
// Package of the melody tone sequencer: operation codes, sequencer states,
// register indexes, reset values and the volume table. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

  // Field and register widths fixed by the interface.
  localparam int OP_W       = 3;
  localparam int IDX_W      = 8;
  localparam int FREQ_W     = 16;
  localparam int DUR_W      = 16;
  localparam int POS_W      = 9;
  localparam int GAP_W      = 8;
  localparam int DIVISOR_W  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int TICK_W     = 32;
  localparam int PERIOD_W   = 8;
  localparam int VOL_W      = 3;
  localparam int LEVEL_W    = 6;
  localparam int PROD_W     = PERIOD_W + LEVEL_W;
  localparam int NOTE_W     = FREQ_W + DUR_W;

  // Default table depth.
  localparam int MAX_NOTES_DEF = 256;

  // Reset values of the configuration registers.
  localparam logic [POS_W-1:0]     SONG_LEN_RESET = 9'd1;
  localparam logic [GAP_W-1:0]     GAP_RESET      = 8'd10;
  localparam logic [DIVISOR_W-1:0] DIVISOR_RESET  = 24'd7812;

  // Volume steps run from 0 to VOLUME_LEVELS-1.
  localparam int VOLUME_LEVELS = 6;

  // Division by 100 as a multiply by 5243 and a right shift by 19; exact for
  // every product of an 8-bit period and a volume level.
  localparam int DUTY_RECIP = 5243;
  localparam int DUTY_SHIFT = 19;
  localparam int SCALED_W   = PROD_W + 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SONG_LENGTH    = 2'd0,
    CFG_GAP_TICKS      = 2'd1,
    CFG_PERIOD_DIVISOR = 2'd2
  } cfg_idx_e;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_LOAD_NOTE = 3'd1,
    OP_START     = 3'd2,
    OP_VOL_UP    = 3'd3,
    OP_VOL_DOWN  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TONE,
    ST_TWAIT,
    ST_MUL,
    ST_SCALE,
    ST_LOAD,
    ST_DONE
  } state_e;

  // Handshake with the period divider.
  typedef struct packed {
    logic                start;
    logic [FREQ_W-1:0]   freq;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [PERIOD_W-1:0] ticks;
  } div_rsp_t;

  // Duty percentage for each volume step.
  function automatic logic [LEVEL_W-1:0] vol_level(input logic [VOL_W-1:0] step);
    logic [LEVEL_W-1:0] lvl;
    case (step)
      3'd0:    lvl = 6'd0;
      3'd1:    lvl = 6'd1;
      3'd2:    lvl = 6'd2;
      3'd3:    lvl = 6'd8;
      3'd4:    lvl = 6'd20;
      3'd5:    lvl = 6'd50;
      default: lvl = 6'd0;
    endcase
    return lvl;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mts_note_ram.sv
// Note table of the melody tone sequencer: one write port, one read port,
// read data registered. Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module mts_note_ram #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mts_period_div.sv
// Tone period divider: divisor / frequency saturated to 8 bits, zero for a
// zero frequency. Restoring division, one quotient bit a cycle. Uses mts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mts_period_div import mts_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output      div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [2:0]           bit_q, bit_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [PERIOD_W-1:0]  quo_q, quo_d;
  logic [DIVISOR_W-1:0] shifted;

  assign shifted = DIVISOR_W'(req_i.freq) << bit_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    bit_d  = bit_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      if ((req_i.freq == '0) || (DIVISOR_W'(req_i.freq) > req_i.divisor)) begin
        quo_d  = '0;
        done_d = 1'b1;
      end else if (req_i.divisor[DIVISOR_W-1:PERIOD_W] >= (DIVISOR_W-PERIOD_W)'(req_i.freq)) begin
        // Quotient of 256 or more saturates.
        quo_d  = '1;
        done_d = 1'b1;
      end else begin
        rem_d  = req_i.divisor;
        quo_d  = '0;
        bit_d  = 3'(PERIOD_W - 1);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (rem_q >= shifted) begin
        rem_d        = rem_q - shifted;
        quo_d[bit_q] = 1'b1;
      end
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        bit_d = bit_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.ticks = quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/melody_tone_sequencer.sv
// Top level of the melody tone sequencer: command port, note table, period
// divider and the sequencer that steps the melody. Uses mts_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Each beat is a command: a millisecond tick, a note load, a start of play or
// a volume step. Pulse start_i while busy_o is low; the command is taken at
// that clock edge and busy_o stays high until its result has been shown.
// Every command gives exactly one result, held on the result ports for a
// single cycle with done_o high, and the receiver must take it in that cycle.
// A load, an unknown code or a tick while stopped goes straight to its result;
// a start of play first reads the note table, and a tick that only counts first
// checks the note and gap timers. A tick that ends a note also reads the note
// table. A tick that sets a new tone waits for the period divider, one quotient
// bit a cycle, then a multiply and a scaling step for the duty value. A volume
// step that changes a sounding tone takes only the multiply and scaling steps.
// Configuration writes are taken at any edge with cfg_we_i high and must only
// be done while busy_o is low. The note table is not cleared by reset; play
// notes only after loading them.
module melody_tone_sequencer import mts_pkg::*; #(
  parameter int MAX_NOTES = MAX_NOTES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Command port.
  input  wire logic                  start_i,
  output      logic                  busy_o,
  input  wire logic [OP_W-1:0]       operation_i,
  input  wire logic [IDX_W-1:0]      note_index_i,
  input  wire logic [FREQ_W-1:0]     note_freq_i,
  input  wire logic [DUR_W-1:0]      note_duration_i,
  // Result port.
  output      logic                  done_o,
  output      logic                  tone_on_o,
  output      logic [PERIOD_W-1:0]   tone_period_o,
  output      logic [PERIOD_W-1:0]   duty_compare_o,
  output      logic                  playing_o,
  output      logic [POS_W-1:0]      note_number_o,
  // Configuration write port.
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AddrW = $clog2(MAX_NOTES);
  localparam logic [12:0] MaxNotesW = 13'(MAX_NOTES);

  // Configuration registers.
  logic [POS_W-1:0]     song_len_q;
  logic [GAP_W-1:0]     gap_ticks_q;
  logic [DIVISOR_W-1:0] divisor_q;

  // Sequencer state.
  state_e               state_q, state_d;
  logic [TICK_W-1:0]    tick_q, tick_d;
  logic [TICK_W-1:0]    note_start_q, note_start_d;
  logic [TICK_W-1:0]    gap_start_q, gap_start_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [FREQ_W-1:0]    freq_q, freq_d;
  logic [DUR_W-1:0]     len_q, len_d;
  logic                 run_q, run_d;
  logic                 first_q, first_d;
  logic                 gap_q, gap_d;
  logic                 sound_q, sound_d;
  logic [VOL_W-1:0]     vol_q, vol_d;
  logic [PERIOD_W-1:0]  period_q, period_d;
  logic [PERIOD_W-1:0]  duty_q, duty_d;
  // Set when the tone update was started by the first tick, so the note
  // length check still follows; cleared for a gap end or a volume step.
  logic                 tone_ret_q, tone_ret_d;
  // The note being fetched lies beyond the table and reads as a zero note.
  logic                 rd_zero_q, rd_zero_d;
  logic [PROD_W-1:0]    prod_q, prod_d;

  // Shared conditions.
  logic                 accept;
  op_e                  op;
  logic [VOL_W-1:0]     vol_step;
  logic                 sounding;
  logic                 note_done;
  logic                 gap_done;
  logic [POS_W:0]       next_pos;
  logic                 last_note;
  logic                 next_in_range;
  logic                 idx_in_range;
  logic [SCALED_W-1:0]  scaled;
  state_e               tone_ret_state;

  // Memory and divider connections.
  logic                 wr_en;
  logic                 rd_en;
  logic [AddrW-1:0]     rd_addr;
  logic [NOTE_W-1:0]    rd_data;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  assign accept = start_i && (state_q == ST_IDLE);
  assign op     = op_e'(operation_i);

  // Volume step after an up or down command, saturating at both ends.
  always_comb begin
    vol_step = vol_q;
    if (op == OP_VOL_UP) begin
      if (vol_q < 3'(VOLUME_LEVELS - 1)) begin
        vol_step = vol_q + 3'd1;
      end
    end else if (vol_q != '0) begin
      vol_step = vol_q - 3'd1;
    end
  end

  // A note sounds audibly while playing, past the first tick, outside a gap,
  // with a frequency that gives a nonzero period (0 < freq <= divisor).
  assign sounding = run_q && !first_q && !gap_q && (freq_q != '0) &&
                    (DIVISOR_W'(freq_q) <= divisor_q);

  assign note_done     = (tick_q - note_start_q) >= TICK_W'(len_q);
  assign gap_done      = (tick_q - gap_start_q) >= TICK_W'(gap_ticks_q);
  assign next_pos      = (POS_W+1)'(pos_q) + (POS_W+1)'(1);
  assign last_note     = next_pos >= (POS_W+1)'(song_len_q);
  assign next_in_range = 13'(next_pos) < MaxNotesW;
  assign idx_in_range  = 13'(note_index_i) < MaxNotesW;
  assign scaled        = SCALED_W'(prod_q) * SCALED_W'(DUTY_RECIP);
  assign tone_ret_state = tone_ret_q ? ST_CHECK : ST_DONE;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_TICK: begin
              if (!run_q) begin
                state_d = ST_DONE;
              end else if (first_q) begin
                state_d = ST_TONE;
              end else begin
                state_d = ST_CHECK;
              end
            end
            OP_START: begin
              state_d = ST_LOAD;
            end
            OP_VOL_UP, OP_VOL_DOWN: begin
              if ((vol_level(vol_step) != '0) && sounding) begin
                state_d = ST_MUL;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (!gap_q) begin
          if (note_done && !last_note) begin
            state_d = ST_LOAD;
          end else begin
            state_d = ST_DONE;
          end
        end else if (gap_done && (freq_q != '0)) begin
          state_d = ST_TONE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_TONE: begin
        state_d = ST_TWAIT;
      end
      ST_TWAIT: begin
        if (div_rsp.done) begin
          if ((div_rsp.ticks == '0) || (vol_level(vol_q) == '0)) begin
            state_d = tone_ret_state;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        state_d = tone_ret_state;
      end
      ST_LOAD: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Handshake outputs and the divider request.
  always_comb begin
    busy_o          = (state_q != ST_IDLE);
    done_o          = (state_q == ST_DONE);
    div_req.start   = (state_q == ST_TONE);
    div_req.freq    = freq_q;
    div_req.divisor = divisor_q;
  end

  // Datapath: every state register keeps its value unless a step changes it.
  always_comb begin
    tick_d       = tick_q;
    note_start_d = note_start_q;
    gap_start_d  = gap_start_q;
    pos_d        = pos_q;
    freq_d       = freq_q;
    len_d        = len_q;
    run_d        = run_q;
    first_d      = first_q;
    gap_d        = gap_q;
    sound_d      = sound_q;
    vol_d        = vol_q;
    period_d     = period_q;
    duty_d       = duty_q;
    tone_ret_d   = tone_ret_q;
    rd_zero_d    = rd_zero_q;
    prod_d       = prod_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = AddrW'(next_pos);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_TICK: begin
              tick_d = tick_q + TICK_W'(1);
              if (run_q && first_q) begin
                // The first tick times the start of note 0 and sets its tone.
                first_d      = 1'b0;
                note_start_d = tick_q + TICK_W'(1);
                tone_ret_d   = 1'b1;
              end
            end
            OP_LOAD_NOTE: begin
              wr_en = idx_in_range;
            end
            OP_START: begin
              // Restart at note 0; the tone waits for the next tick.
              pos_d     = '0;
              first_d   = 1'b1;
              run_d     = 1'b1;
              gap_d     = 1'b0;
              rd_en     = 1'b1;
              rd_addr   = '0;
              rd_zero_d = 1'b0;
            end
            OP_VOL_UP, OP_VOL_DOWN: begin
              vol_d = vol_step;
              if (vol_level(vol_step) == '0) begin
                sound_d = 1'b0;
              end else if (sounding) begin
                sound_d    = 1'b1;
                tone_ret_d = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (!gap_q) begin
          if (note_done) begin
            gap_d       = 1'b1;
            gap_start_d = tick_q;
            sound_d     = 1'b0;
            if (last_note) begin
              run_d = 1'b0;
              pos_d = '0;
            end else begin
              pos_d     = next_pos[POS_W-1:0];
              rd_en     = next_in_range;
              rd_zero_d = !next_in_range;
            end
          end
        end else if (gap_done) begin
          // The next note, or a rest with the tone left off, is timed from the end of the gap.
          gap_d        = 1'b0;
          note_start_d = tick_q;
          tone_ret_d   = 1'b0;
        end
      end
      ST_TWAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.ticks == '0) begin
            // Zero period: the tone stops, period and duty keep their values.
            sound_d = 1'b0;
          end else begin
            period_d = div_rsp.ticks - PERIOD_W'(1);
            sound_d  = (vol_level(vol_q) != '0);
          end
        end
      end
      ST_MUL: begin
        prod_d = PROD_W'(period_q) * PROD_W'(vol_level(vol_q));
      end
      ST_SCALE: begin
        duty_d = PERIOD_W'(scaled >> DUTY_SHIFT);
      end
      ST_LOAD: begin
        if (rd_zero_q) begin
          freq_d = '0;
          len_d  = '0;
        end else begin
          freq_d = rd_data[FREQ_W-1:0];
          len_d  = rd_data[NOTE_W-1:FREQ_W];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tick_q       <= '0;
      note_start_q <= '0;
      gap_start_q  <= '0;
      pos_q        <= '0;
      freq_q       <= '0;
      len_q        <= '0;
      run_q        <= 1'b0;
      first_q      <= 1'b0;
      gap_q        <= 1'b0;
      sound_q      <= 1'b0;
      vol_q        <= '0;
      period_q     <= '0;
      duty_q       <= '0;
      tone_ret_q   <= 1'b0;
      rd_zero_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      tick_q       <= tick_d;
      note_start_q <= note_start_d;
      gap_start_q  <= gap_start_d;
      pos_q        <= pos_d;
      freq_q       <= freq_d;
      len_q        <= len_d;
      run_q        <= run_d;
      first_q      <= first_d;
      gap_q        <= gap_d;
      sound_q      <= sound_d;
      vol_q        <= vol_d;
      period_q     <= period_d;
      duty_q       <= duty_d;
      tone_ret_q   <= tone_ret_d;
      rd_zero_q    <= rd_zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      song_len_q  <= SONG_LEN_RESET;
      gap_ticks_q <= GAP_RESET;
      divisor_q   <= DIVISOR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SONG_LENGTH:    song_len_q  <= cfg_data_i[POS_W-1:0];
        CFG_GAP_TICKS:      gap_ticks_q <= cfg_data_i[GAP_W-1:0];
        CFG_PERIOD_DIVISOR: divisor_q   <= cfg_data_i[DIVISOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mts_note_ram #(
    .DEPTH  (MAX_NOTES),
    .DATA_W (NOTE_W),
    .ADDR_W (AddrW)
  ) u_note_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AddrW'(note_index_i)),
    .wdata_i ({note_duration_i, note_freq_i}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  mts_period_div u_period_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign tone_on_o      = sound_q;
  assign tone_period_o  = period_q;
  assign duty_compare_o = duty_q;
  assign playing_o      = run_q;
  assign note_number_o  = pos_q;

endmodule

`default_nettype wire

FILE: hw/rtl/mts_checker.sv
// Port-level checker of the melody tone sequencer and its bind to the top
// level. Depends on mts_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mts_checker import mts_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start_i,
  input wire logic             busy_o,
  input wire logic             done_o,
  input wire logic             tone_on_o,
  input wire logic             playing_o,
  input wire logic [POS_W-1:0] note_number_o
);

  // A taken command keeps the block busy until its result beat.
  `ASSERT_RST(a_accept_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o, "command not held busy")

  // A result beat lasts one cycle and frees the block.
  `ASSERT_RST(a_done_single, clk_i, rst_ni, done_o |=> (!done_o && !busy_o), "result beat not single")

  // Once play has stopped the tone is off and the position is back at zero.
  `ASSERT_ALWAYS(a_stopped_quiet, clk_i, !playing_o |-> (!tone_on_o && (note_number_o == '0)), "stopped but not quiet")

  // Without a command the visible play state does not move.
  `ASSERT_RST(a_idle_stable, clk_i, rst_ni, (!busy_o && !start_i) |=> ($stable(tone_on_o) && $stable(playing_o) && $stable(note_number_o)), "state moved while idle")

endmodule

bind melody_tone_sequencer mts_checker u_mts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .tone_on_o     (tone_on_o),
  .playing_o     (playing_o),
  .note_number_o (note_number_o)
);

`default_nettype wire

FILE: verif/melody_tone_sequencer_tb.sv
// Self-checking testbench for melody_tone_sequencer: drives note loads, play
// starts, volume steps and millisecond ticks, and checks every result beat
// against a cycle-free tone model. Depends on mts_pkg and the top-level RTL.
`timescale 1ns / 1ps

module melody_tone_sequencer_tb import mts_pkg::*; ();

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 11;
  // Longest stretch without any beat: a sender pause, a tone update and a
  // register write, taken many times over.
  localparam int QUIET_LIMIT  = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES  = 32;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 55;
  // A small note table keeps the walk past its end short.
  localparam int TB_NOTES     = 16;
  localparam int TB_ADDR_W    = $clog2(TB_NOTES);
  // A song length that walks a song past the end of the note table.
  localparam int LONG_SONG    = TB_NOTES + 2;
  localparam int LONG_GUARD   = 2000;

  // One result beat as seen on the result ports.
  typedef struct packed {
    logic                tone_on;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] duty;
    logic                playing;
    logic [POS_W-1:0]    note_number;
  } tone_status_t;

  // Tracks the sequencer state command by command and keeps the tone
  // status that each accepted command must produce, oldest first.
  class tone_status_tracker;
    bit [NOTE_W-1:0]    notes [TB_NOTES];
    bit [TICK_W-1:0]    ticks, note_t0, gap_t0;
    bit [POS_W-1:0]     pos;
    bit [FREQ_W-1:0]    cur_freq;
    bit [DUR_W-1:0]     cur_len;
    bit                 running, first, in_gap, sounding;
    bit [VOL_W-1:0]     vol;
    bit [PERIOD_W-1:0]  period, duty;
    bit [POS_W-1:0]     song_len;
    bit [GAP_W-1:0]     gap_len;
    bit [DIVISOR_W-1:0] divisor;
    int unsigned        vol_pct [VOLUME_LEVELS] = '{0, 1, 2, 8, 20, 50};
    tone_status_t       status_due [$];
    int unsigned        mismatch_count;

    function new();
      song_len = SONG_LEN_RESET;
      gap_len  = GAP_RESET;
      divisor  = DIVISOR_RESET;
    endfunction

    function void set_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SONG_LENGTH:    song_len = data[POS_W-1:0];
        CFG_GAP_TICKS:      gap_len  = data[GAP_W-1:0];
        CFG_PERIOD_DIVISOR: divisor  = data[DIVISOR_W-1:0];
        default: ;
      endcase
    endfunction

    // Period ticks for a frequency, saturated; zero means no tone.
    function int unsigned period_of(bit [FREQ_W-1:0] freq);
      int unsigned q;
      if (freq == 0) return 0;
      q = divisor / freq;
      return (q > 255) ? 255 : q;
    endfunction

    function void set_duty();
      int unsigned lvl;
      lvl = vol_pct[vol];
      if (lvl == 0) begin
        sounding = 1'b0;
      end else if (running) begin
        sounding = 1'b1;
        duty = PERIOD_W'((period * lvl) / 100);
      end
    endfunction

    function void set_tone(bit [FREQ_W-1:0] freq);
      int unsigned t;
      t = period_of(freq);
      if (t == 0) begin
        sounding = 1'b0;
      end else begin
        sounding = 1'b1;
        period = PERIOD_W'(t - 1);
        set_duty();
      end
    endfunction

    // Positions past the table read as a rest of zero length.
    function void fetch_note(bit [POS_W-1:0] at);
      bit [NOTE_W-1:0] e;
      e = (at < TB_NOTES) ? notes[at[TB_ADDR_W-1:0]] : '0;
      cur_freq = e[FREQ_W-1:0];
      cur_len  = e[NOTE_W-1:FREQ_W];
    endfunction

    function void ms_tick();
      int unsigned following;
      ticks++;
      if (!running) return;
      if (first) begin
        first = 1'b0;
        note_t0 = ticks;
        set_tone(cur_freq);
      end
      if (!in_gap) begin
        if (ticks - note_t0 >= cur_len) begin
          following = pos + 1;
          in_gap = 1'b1;
          gap_t0 = ticks;
          sounding = 1'b0;
          if (following >= song_len) begin
            running = 1'b0;
            pos = '0;
          end else begin
            pos = POS_W'(following);
            fetch_note(pos);
          end
        end
      end else if (ticks - gap_t0 >= gap_len) begin
        in_gap = 1'b0;
        note_t0 = ticks;
        if (cur_freq != 0) set_tone(cur_freq);
      end
    endfunction

    // The duty is only refreshed while a note is audibly sounding.
    function void step_volume(bit up);
      if (up && vol + 1 < VOLUME_LEVELS) vol++;
      else if (!up && vol > 0) vol--;
      if (vol_pct[vol] == 0) sounding = 1'b0;
      else if (running && !first && !in_gap && period_of(cur_freq) != 0) set_duty();
    endfunction

    // Loads beyond the table are dropped.
    function void take_command(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                               logic [FREQ_W-1:0] freq, logic [DUR_W-1:0] dur);
      tone_status_t s;
      case (op)
        OP_TICK:      ms_tick();
        OP_LOAD_NOTE: if (idx < TB_NOTES) notes[idx[TB_ADDR_W-1:0]] = {dur, freq};
        OP_START: begin
          pos = '0;
          fetch_note('0);
          first   = 1'b1;
          running = 1'b1;
          in_gap  = 1'b0;
        end
        OP_VOL_UP:    step_volume(1'b1);
        OP_VOL_DOWN:  step_volume(1'b0);
        default: ;
      endcase
      s.tone_on     = sounding;
      s.period      = period;
      s.duty        = duty;
      s.playing     = running;
      s.note_number = pos;
      status_due.push_back(s);
    endfunction

    function void compare_field(string field, logic [POS_W-1:0] want,
                                logic [POS_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_status(tone_status_t got);
      tone_status_t want;
      if (status_due.size() == 0) begin
        $display("%0t: result beat with none expected, got tone_on %0d period %0d",
                 $time, got.tone_on, got.period);
        mismatch_count++;
        return;
      end
      want = status_due.pop_front();
      compare_field("tone_on", want.tone_on, got.tone_on);
      compare_field("tone_period", want.period, got.period);
      compare_field("duty_compare", want.duty, got.duty);
      compare_field("playing", want.playing, got.playing);
      compare_field("note_number", want.note_number, got.note_number);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [OP_W-1:0]       operation_i;
  logic [IDX_W-1:0]      note_index_i;
  logic [FREQ_W-1:0]     note_freq_i;
  logic [DUR_W-1:0]      note_duration_i;
  logic                  done_o;
  logic                  tone_on_o;
  logic [PERIOD_W-1:0]   tone_period_o;
  logic [PERIOD_W-1:0]   duty_compare_o;
  logic                  playing_o;
  logic [POS_W-1:0]      note_number_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tone_status_tracker model;
  bit                 pause_ok;
  int                 quiet_cycles;

  melody_tone_sequencer #(
    .MAX_NOTES(TB_NOTES)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .note_index_i   (note_index_i),
    .note_freq_i    (note_freq_i),
    .note_duration_i(note_duration_i),
    .done_o         (done_o),
    .tone_on_o      (tone_on_o),
    .tone_period_o  (tone_period_o),
    .duty_compare_o (duty_compare_o),
    .playing_o      (playing_o),
    .note_number_o  (note_number_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Outputs are sampled at the rising edge, so the values seen are the ones
  // held during the cycle that the edge ends. A result beat is only valid
  // for that one cycle, and the receiver never stalls.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      model.check_status('{tone_on_o, tone_period_o, duty_compare_o, playing_o,
                           note_number_o});
    end
  end

  // The run fails as stuck once quiet_cycles, cleared by reset and by every
  // command and result beat, reaches QUIET_LIMIT.
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (start_i === 1'b1 && busy_o === 1'b0) || done_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL melody_tone_sequencer");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one command and returns at the edge that takes it. start_i is
  // left high so that a following command keeps it up without a drop; the
  // next pause or settle lowers it.
  task automatic send_command(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic [FREQ_W-1:0] freq,
                              input logic [DUR_W-1:0] dur);
    start_i         <= 1'b1;
    operation_i     <= op;
    note_index_i    <= idx;
    note_freq_i     <= freq;
    note_duration_i <= dur;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    model.take_command(op, idx, freq, dur);
  endtask

  // Fields that the operation does not use still carry random values.
  task automatic send_op(input logic [OP_W-1:0] op);
    send_command(op, IDX_W'($urandom), FREQ_W'($urandom), DUR_W'($urandom));
  endtask

  task automatic hold_off(input int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic maybe_pause();
    if (pause_ok && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 9));
  endtask

  // Stops sending until every result has come back and the block is idle.
  task automatic wait_settled();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (model.status_due.size() != 0 || busy_o !== 1'b0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all three registers on back-to-back edges; only called when
  // settled. Bits above a register's width carry noise.
  task automatic program_registers(input logic [POS_W-1:0] song,
                                   input logic [GAP_W-1:0] gap,
                                   input logic [DIVISOR_W-1:0] divisor);
    logic [CFG_DATA_W-1:0] data;
    data = {(CFG_DATA_W - POS_W)'($urandom), song};
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SONG_LENGTH;
    cfg_data_i <= data;
    @(posedge clk_i);
    model.set_register(CFG_SONG_LENGTH, data);
    data = {(CFG_DATA_W - GAP_W)'($urandom), gap};
    cfg_idx_i  <= CFG_GAP_TICKS;
    cfg_data_i <= data;
    @(posedge clk_i);
    model.set_register(CFG_GAP_TICKS, data);
    data = divisor;
    cfg_idx_i  <= CFG_PERIOD_DIVISOR;
    cfg_data_i <= data;
    @(posedge clk_i);
    model.set_register(CFG_PERIOD_DIVISOR, data);
    cfg_we_i <= 1'b0;
  endtask

  // Mix of rests, low notes whose period may saturate, and arbitrary values.
  function automatic logic [FREQ_W-1:0] random_freq();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return FREQ_W'($urandom_range(1, 64));
      2:       return FREQ_W'($urandom_range(65, 4000));
      default: return FREQ_W'($urandom);
    endcase
  endfunction

  // Mostly short notes so that songs finish; now and then a long one.
  function automatic logic [DUR_W-1:0] random_duration();
    if ($urandom_range(0, 15) == 0) return DUR_W'($urandom);
    return DUR_W'($urandom_range(0, 6));
  endfunction

  // Random commands weighted toward ticks while a song plays and toward
  // starts while it is stopped. Unknown codes and ticks while stopped do
  // nothing, so they are not counted. Loads mostly land inside the table.
  task automatic random_phase(input int target);
    int              counted;
    int              pick;
    bit              no_effect;
    logic [OP_W-1:0] op;
    counted = 0;
    while (counted < target) begin
      maybe_pause();
      if (pause_ok && $urandom_range(0, 39) == 0) wait_settled();
      pick = $urandom_range(0, 99);
      no_effect = 1'b0;
      if (model.running) begin
        if (pick < 70)      op = OP_TICK;
        else if (pick < 78) op = OP_VOL_UP;
        else if (pick < 86) op = OP_VOL_DOWN;
        else if (pick < 92) op = OP_LOAD_NOTE;
        else if (pick < 96) op = OP_START;
        else begin
          op = OP_W'($urandom_range(OP_VOL_DOWN + 1, (1 << OP_W) - 1));
          no_effect = 1'b1;
        end
      end else begin
        if (pick < 45)      op = OP_START;
        else if (pick < 60) op = OP_LOAD_NOTE;
        else if (pick < 70) op = OP_VOL_UP;
        else if (pick < 80) op = OP_VOL_DOWN;
        else if (pick < 90) begin
          op = OP_TICK;
          no_effect = 1'b1;
        end else begin
          op = OP_W'($urandom_range(OP_VOL_DOWN + 1, (1 << OP_W) - 1));
          no_effect = 1'b1;
        end
      end
      if (op == OP_LOAD_NOTE) begin
        send_command(op, ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) :
                     IDX_W'($urandom_range(0, TB_NOTES - 1)),
                     random_freq(), random_duration());
      end else begin
        send_op(op);
      end
      if (!no_effect) counted++;
    end
  endtask

  initial begin
    int guard;
    model = new();
    pause_ok        = 1'b0;
    rst_ni          <= 1'b0;
    start_i         <= 1'b0;
    operation_i     <= OP_TICK;
    note_index_i    <= '0;
    note_freq_i     <= '0;
    note_duration_i <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_SONG_LENGTH;
    cfg_data_i      <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, registers at their reset values. Volume down at the
    // bottom step, the unused operation codes and a tick while stopped.
    send_op(OP_VOL_DOWN);
    for (int code = OP_VOL_DOWN + 1; code < (1 << OP_W); code++) begin
      if (code[0]) send_command(OP_W'(code), '1, '1, '1);
      else send_command(OP_W'(code), '0, '0, '0);
    end
    send_command(OP_TICK, '1, '1, '1);

    // A plain note, a rest, a note above the divisor (tone off), a note whose
    // period saturates, a load at the last table slot with top values, and a
    // load beyond the table that is dropped.
    send_command(OP_LOAD_NOTE, IDX_W'(0), FREQ_W'(440), DUR_W'(2));
    send_command(OP_LOAD_NOTE, IDX_W'(1), '0, DUR_W'(1));
    send_command(OP_LOAD_NOTE, IDX_W'(2), '1, '0);
    send_command(OP_LOAD_NOTE, IDX_W'(3), FREQ_W'(1), DUR_W'(1));
    send_command(OP_LOAD_NOTE, IDX_W'(TB_NOTES - 1), '1, '1);
    send_command(OP_LOAD_NOTE, '1, '1, '1);

    // Four-note song with a one-tick gap. Volume goes past the top step,
    // then changes while the first note sounds; play restarts mid-song.
    wait_settled();
    program_registers(POS_W'(4), GAP_W'(1), DIVISOR_RESET);
    repeat (VOLUME_LEVELS) send_op(OP_VOL_UP);
    send_op(OP_START);
    send_op(OP_TICK);
    send_op(OP_VOL_DOWN);
    repeat (5) send_op(OP_TICK);
    send_op(OP_START);
    repeat (2) send_op(OP_TICK);

    // Song length zero still plays the first note; divisor 1 puts every
    // frequency above 1 above it.
    wait_settled();
    program_registers('0, '0, DIVISOR_W'(1));
    send_op(OP_START);
    repeat (2) send_op(OP_TICK);

    // Fill the whole note table so that no later play reads an entry that
    // was never written. Durations stay tiny for the long song below.
    wait_settled();
    program_registers(SONG_LEN_RESET, GAP_RESET, DIVISOR_RESET);
    pause_ok = 1'b1;
    for (int i = 0; i < TB_NOTES; i++) begin
      maybe_pause();
      send_command(OP_LOAD_NOTE, IDX_W'(i), random_freq(),
                   ($urandom_range(0, 3) == 0) ? DUR_W'($urandom_range(1, 2)) : '0);
    end

    // A song longer than the table: positions past the end play as empty
    // rests, and play ends at the song length.
    wait_settled();
    program_registers(POS_W'(LONG_SONG), '0, DIVISOR_RESET);
    send_op(OP_START);
    guard = 0;
    while (model.running && guard < LONG_GUARD) begin
      maybe_pause();
      send_op(OP_TICK);
      guard++;
    end

    // Random phases, each under its own register setting. The first three
    // hit the extremes; the last one runs with no sender pauses.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_settled();
      case (phase)
        0: program_registers(POS_W'(1), '0, DIVISOR_W'(1));
        1: program_registers(POS_W'(TB_NOTES), '1, '1);
        2: program_registers('0, GAP_W'(3), DIVISOR_RESET);
        default: begin
          program_registers(($urandom_range(0, 7) == 0) ? '0 : POS_W'($urandom_range(1, 12)),
                            GAP_W'($urandom_range(0, 4)),
                            ($urandom_range(0, 1) == 0) ? DIVISOR_RESET :
                            DIVISOR_W'($urandom_range(1, (1 << DIVISOR_W) - 1)));
        end
      endcase
      pause_ok = (phase != PHASES - 1) && ($urandom_range(0, 2) != 0);
      random_phase(PHASE_ITEMS);
    end

    wait_settled();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (model.mismatch_count == 0 && model.status_due.size() == 0) begin
      $display("PASS melody_tone_sequencer");
    end else begin
      $display("%0t: %0d mismatches, %0d results missing", $time,
               model.mismatch_count, model.status_due.size());
      $display("FAIL melody_tone_sequencer");
    end
    $finish;
  end

endmodule
